// ----- rtl/core/ccc_pkg.sv -----
// calendar clock counter package: word types, calendar constants, month length and leap helpers
// no dependencies; used by the stage, core and top files of the calendar clock block
`default_nettype none

package ccc_pkg;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  // input word as carried through the input register
  typedef struct packed {
    logic        command;
    logic [5:0]  set_second;
    logic [5:0]  set_minute;
    logic [4:0]  set_hour;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [13:0] set_year;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic [3:0]  hour_twelve;
    logic        is_pm;
    logic        set_rejected;
  } out_word_t;

  // input register to calendar core
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

  // calendar core to result register
  typedef struct packed {
    logic      load;
    out_word_t word;
  } result_t;

  localparam logic [5:0]  SEC_LAST    = 6'd59;
  localparam logic [5:0]  MIN_LAST    = 6'd59;
  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [4:0]  HOUR_HALF   = 5'd12;
  localparam logic [3:0]  HOUR12_TOP  = 4'd12;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [4:0]  FEB_LEAP    = 5'd29;
  localparam logic [13:0] YEAR_LAST   = 14'd9999;
  localparam logic [13:0] YEAR_RESET  = 14'd2000;
  localparam logic [13:0] YEAR_CENT   = 14'd100;

  // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // month lengths, codes 13 to 15 and 0 give 0 so no day fits
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

  function automatic logic leap_year(logic [13:0] year);
    logic [26:0] prod;
    logic [7:0]  quot;
    logic [14:0] back;
    logic        div100;
    prod   = 27'(year) * 27'(RECIP_100);
    quot   = prod[RECIP_SHIFT +: 8];
    back   = 15'(quot) * 15'(YEAR_CENT);
    div100 = (back[13:0] == year);
    // divisible by 400 is divisible by 100 and by 16
    return (year[1:0] == 2'b00) && (!div100 || (year[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] days_in_month(logic [3:0] month, logic [13:0] year);
    logic [4:0] days;
    days = MONTH_LEN[month];
    if ((month == MONTH_FEB) && leap_year(year)) begin
      days = FEB_LEAP;
    end
    return days;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ccc_in_if.sv -----
// input channel of the calendar clock: valid/ready handshake and command word fields
// no dependencies
`default_nettype none

interface ccc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  set_second;
  logic [5:0]  set_minute;
  logic [4:0]  set_hour;
  logic [4:0]  set_day;
  logic [3:0]  set_month;
  logic [13:0] set_year;

  modport source (
    output valid, command, set_second, set_minute, set_hour, set_day, set_month, set_year,
    input  ready
  );

  modport sink (
    input  valid, command, set_second, set_minute, set_hour, set_day, set_month, set_year,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/ccc_out_if.sv -----
// result channel of the calendar clock: valid/ready handshake and date/time fields
// no dependencies
`default_nettype none

interface ccc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cur_second;
  logic [5:0]  cur_minute;
  logic [4:0]  cur_hour;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [13:0] cur_year;
  logic [3:0]  hour_twelve;
  logic        is_pm;
  logic        set_rejected;

  modport source (
    output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year,
           hour_twelve, is_pm, set_rejected,
    input  ready
  );

  modport sink (
    input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year,
           hour_twelve, is_pm, set_rejected,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/ccc_in_stage.sv -----
// input register of the calendar clock: captures one command word per handshake
// depends on ccc_pkg
`default_nettype none

module ccc_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ccc_pkg::in_word_t in_word,
  input  wire logic             out_free,
  output ccc_pkg::stage_t       stage
);

  logic              valid_r;
  logic              valid_nxt;
  ccc_pkg::in_word_t word_r;
  logic              accept;

  // register empties whenever the result register can take its word
  assign in_ready  = !valid_r || out_free;
  assign accept    = in_valid && in_ready;
  assign valid_nxt = accept || (valid_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_word;
    end
  end

  assign stage.valid = valid_r;
  assign stage.word  = word_r;

endmodule

`default_nettype wire

// ----- rtl/core/ccc_core.sv -----
// calendar core: time and date counters, tick carry chain, set range check
// depends on ccc_pkg
`default_nettype none

module ccc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ccc_pkg::stage_t stage,
  input  wire logic            out_free,
  output ccc_pkg::result_t     result
);

  logic [5:0]  sec_r,   sec_nxt;
  logic [5:0]  min_r,   min_nxt;
  logic [4:0]  hour_r,  hour_nxt;
  logic [4:0]  day_r,   day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r,  year_nxt;

  logic        step;
  logic        sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
  logic [4:0]  cur_days;
  logic [4:0]  set_days;
  logic        set_ok;
  logic        rejected;
  logic [4:0]  hour_mod;
  logic        pm;

  assign step = stage.valid && out_free;

  // carry chain of a one-second tick
  always_comb begin
    cur_days   = ccc_pkg::days_in_month(month_r, year_r);
    sec_wrap   = (sec_r == ccc_pkg::SEC_LAST);
    min_wrap   = sec_wrap && (min_r == ccc_pkg::MIN_LAST);
    hour_wrap  = min_wrap && (hour_r == ccc_pkg::HOUR_LAST);
    day_wrap   = hour_wrap && (day_r >= cur_days);
    month_wrap = day_wrap && (month_r >= ccc_pkg::MONTH_LAST);
  end

  // set check, every field in range and the day inside its month
  always_comb begin
    set_days = ccc_pkg::days_in_month(stage.word.set_month, stage.word.set_year);
    set_ok   = (stage.word.set_second <= ccc_pkg::SEC_LAST) &&
               (stage.word.set_minute <= ccc_pkg::MIN_LAST) &&
               (stage.word.set_hour <= ccc_pkg::HOUR_LAST) &&
               (stage.word.set_month inside {[ccc_pkg::MONTH_FIRST:ccc_pkg::MONTH_LAST]}) &&
               (stage.word.set_year <= ccc_pkg::YEAR_LAST) &&
               (stage.word.set_day >= ccc_pkg::DAY_FIRST) &&
               (stage.word.set_day <= set_days);
  end

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    rejected  = 1'b0;
    if (step) begin
      if (stage.word.command == ccc_pkg::CMD_SET) begin
        if (set_ok) begin
          sec_nxt   = stage.word.set_second;
          min_nxt   = stage.word.set_minute;
          hour_nxt  = stage.word.set_hour;
          day_nxt   = stage.word.set_day;
          month_nxt = stage.word.set_month;
          year_nxt  = stage.word.set_year;
        end else begin
          rejected = 1'b1;
        end
      end else begin
        sec_nxt = sec_wrap ? 6'd0 : sec_r + 6'd1;
        if (sec_wrap) begin
          min_nxt = min_wrap ? 6'd0 : min_r + 6'd1;
        end
        if (min_wrap) begin
          hour_nxt = hour_wrap ? 5'd0 : hour_r + 5'd1;
        end
        if (hour_wrap) begin
          day_nxt = day_wrap ? ccc_pkg::DAY_FIRST : day_r + 5'd1;
        end
        if (day_wrap) begin
          month_nxt = month_wrap ? ccc_pkg::MONTH_FIRST : month_r + 4'd1;
        end
        if (month_wrap) begin
          year_nxt = (year_r >= ccc_pkg::YEAR_LAST) ? 14'd0 : year_r + 14'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= 6'd0;
      min_r   <= 6'd0;
      hour_r  <= 5'd0;
      day_r   <= ccc_pkg::DAY_FIRST;
      month_r <= ccc_pkg::MONTH_FIRST;
      year_r  <= ccc_pkg::YEAR_RESET;
    end else begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
    end
  end

  // 12-hour view of the new hour
  always_comb begin
    pm       = (hour_nxt >= ccc_pkg::HOUR_HALF);
    hour_mod = pm ? hour_nxt - ccc_pkg::HOUR_HALF : hour_nxt;
  end

  always_comb begin
    result.load              = step;
    result.word.cur_second   = sec_nxt;
    result.word.cur_minute   = min_nxt;
    result.word.cur_hour     = hour_nxt;
    result.word.cur_day      = day_nxt;
    result.word.cur_month    = month_nxt;
    result.word.cur_year     = year_nxt;
    result.word.hour_twelve  = (hour_mod == 5'd0) ? ccc_pkg::HOUR12_TOP : hour_mod[3:0];
    result.word.is_pm        = pm;
    result.word.set_rejected = rejected;
  end

endmodule

`default_nettype wire

// ----- rtl/core/ccc_out_stage.sv -----
// result register of the calendar clock: holds one result word until taken
// depends on ccc_pkg
`default_nettype none

module ccc_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ccc_pkg::result_t result,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ccc_pkg::out_word_t    out_word
);

  logic               valid_r;
  logic               valid_nxt;
  ccc_pkg::out_word_t word_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = result.load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      word_r <= result.word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

// ----- rtl/core/calendar_clock_counter_top.sv -----
// top level of the gregorian calendar clock: input register, calendar core, result register
// depends on ccc_pkg, ccc_in_if, ccc_out_if, ccc_in_stage, ccc_core, ccc_out_stage
// an input word passes the input register and then the result register before its result is valid
// throughput: 1 word per cycle while the result register is free; the tick carry chain and set check are combinational
// the input side takes a new word while a finished result waits, as long as a slot is free
// reset (synchronous, active low): 00:00:00 on 1 january 2000, both stages empty
`default_nettype none

module calendar_clock_counter_top (
  input  wire logic clk,
  input  wire logic rst_n,
  ccc_in_if.sink    in_chan,
  ccc_out_if.source out_chan
);

  ccc_pkg::in_word_t  in_word;
  ccc_pkg::out_word_t out_word;
  ccc_pkg::stage_t    stage;
  ccc_pkg::result_t   result;
  logic               out_free;
  logic               in_ready;
  logic               out_valid;

  // gather the command word from the channel
  assign in_word.command    = in_chan.command;
  assign in_word.set_second = in_chan.set_second;
  assign in_word.set_minute = in_chan.set_minute;
  assign in_word.set_hour   = in_chan.set_hour;
  assign in_word.set_day    = in_chan.set_day;
  assign in_word.set_month  = in_chan.set_month;
  assign in_word.set_year   = in_chan.set_year;
  assign in_chan.ready      = in_ready;

  // input register, drains whenever the result register has room
  ccc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_free (out_free),
    .stage    (stage)
  );

  // counters update in the same cycle the result word is loaded
  ccc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .out_free (out_free),
    .result   (result)
  );

  // result register, holds the word while the sink stalls
  ccc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_word  (out_word)
  );

  // spread the result word onto the channel
  assign out_chan.valid        = out_valid;
  assign out_chan.cur_second   = out_word.cur_second;
  assign out_chan.cur_minute   = out_word.cur_minute;
  assign out_chan.cur_hour     = out_word.cur_hour;
  assign out_chan.cur_day      = out_word.cur_day;
  assign out_chan.cur_month    = out_word.cur_month;
  assign out_chan.cur_year     = out_word.cur_year;
  assign out_chan.hour_twelve  = out_word.hour_twelve;
  assign out_chan.is_pm        = out_word.is_pm;
  assign out_chan.set_rejected = out_word.set_rejected;

endmodule

`default_nettype wire
